// ===== rtl/core/gtl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtl_pkg: shared types and constants for the glyph text layout block
// Result kinds, register indexes, field widths.
// ----------------------------------------------------------------------------
package gtl_pkg;

  typedef enum logic [1:0] {
    KIND_GLYPH = 2'd0,
    KIND_SPACE = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  localparam logic [1:0] REG_GLYPH_COUNT = 2'd0;
  localparam logic [1:0] REG_SCALE       = 2'd1;
  localparam logic [1:0] REG_ORIGIN_X    = 2'd2;
  localparam logic [1:0] REG_ORIGIN_Y    = 2'd3;

  localparam logic       REQ_ENTRY = 1'b0;
  localparam logic       REQ_TEXT  = 1'b1;

  localparam logic [20:0] SPACE_CODE = 21'h20;
  localparam logic [20:0] MAX_RUNE   = 21'h10FFFF;
  localparam int unsigned ENTRY_W    = 21 + 64 + 48;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) return 32'sh7FFFFFFF;
    else if (v < -50'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

endpackage

// ===== rtl/core/glyph_text_layout.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_text_layout: UTF-8 text to glyph quads over a sorted glyph table
// Decodes text bytes, binary-searches the glyph memory and places quads.
// ----------------------------------------------------------------------------
// channel | dir | handshake           | payload
// in      | in  | in_valid/in_ready   | req_type .. last_byte
// out     | out | out_valid/out_ready | kind .. is_last
// apb     | in  | psel/penable/pready | paddr, pwdata, prdata
//
// Entry write: a single memory write. Text byte: a decode step, then per search
// step an index, a memory read and a compare, up to log2(count)+1 steps, then
// multiply and sum steps and up to two result items, the end item last. The
// single glyph memory read port sets the pace, and a new request is taken only
// in S_IDLE. Reset clears decoder, cursor, glyph count and origins, sets scale
// to 256, and the memory needs no clearing. Output stalls hold the sequencer.
// ----------------------------------------------------------------------------
module glyph_text_layout
  import gtl_pkg::*;
#(
  parameter int unsigned GLYPH_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic [7:0]         entry_index_i,
  input  logic [20:0]        glyph_code_i,
  input  logic signed [15:0] source_x_i,
  input  logic signed [15:0] source_y_i,
  input  logic signed [15:0] source_w_i,
  input  logic signed [15:0] source_h_i,
  input  logic signed [15:0] offset_x_i,
  input  logic signed [15:0] offset_y_i,
  input  logic signed [15:0] advance_x_i,
  input  logic [7:0]         text_byte_i,
  input  logic               last_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic signed [31:0] dest_left_o,
  output logic signed [31:0] dest_top_o,
  output logic signed [31:0] dest_right_o,
  output logic signed [31:0] dest_bottom_o,
  output logic signed [15:0] tex_x_o,
  output logic signed [15:0] tex_y_o,
  output logic signed [15:0] tex_w_o,
  output logic signed [15:0] tex_h_o,
  output logic signed [31:0] total_width_o,
  output logic               is_last_o
);

  localparam int unsigned AW = (GLYPH_DEPTH > 1) ? $clog2(GLYPH_DEPTH) : 1;
  localparam int unsigned CW = $clog2(GLYPH_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_READ, S_CMP, S_MUL, S_SUM, S_GLYPH, S_END
  } state_e;

  state_e              state_q;
  logic [8:0]          glyph_count_q;
  logic [15:0]         scale_q;
  logic signed [31:0]  origin_x_q, origin_y_q;
  logic [20:0]         rune_q;
  logic [1:0]          pend_q;
  logic signed [31:0]  cursor_q;
  logic                last_q;
  logic [CW-1:0]       lo_q, hi_q;
  logic [AW-1:0]       mid_q;
  logic signed [32:0]  m_off_x_q, m_off_y_q, m_w_q, m_h_q, m_adv_q;

  logic [ENTRY_W-1:0]  rdata;
  logic [20:0]         r_code;
  logic signed [15:0]  r_sx, r_sy, r_sw, r_sh, r_ox, r_oy, r_ax;
  assign {r_code, r_sh, r_sw, r_sy, r_sx, r_ax, r_oy, r_ox} = rdata;

  logic [CW-1:0] lim;
  logic [CW:0]   mid_sum;
  always_comb begin
    if ({{(32-9){1'b0}}, glyph_count_q} > 32'(GLYPH_DEPTH)) lim = CW'(GLYPH_DEPTH);
    else lim = CW'(glyph_count_q);
    mid_sum = ({1'b0, lo_q} + {1'b0, hi_q}) >> 1;
  end

  logic in_acc, wr_en;
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign wr_en      = in_acc && (req_type_i == REQ_ENTRY);
  assign pready     = 1'b1;

  gtl_ram #(.WIDTH(ENTRY_W), .DEPTH(GLYPH_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (AW'(entry_index_i)),
    .wdata_i ({glyph_code_i, source_h_i, source_w_i, source_y_i, source_x_i,
               advance_x_i, offset_y_i, offset_x_i}),
    .raddr_i (mid_q),
    .rdata_o (rdata)
  );

  always_comb begin
    unique case (paddr[3:2])
      REG_GLYPH_COUNT: prdata = {23'd0, glyph_count_q};
      REG_SCALE:       prdata = {16'd0, scale_q};
      REG_ORIGIN_X:    prdata = origin_x_q;
      REG_ORIGIN_Y:    prdata = origin_y_q;
      default:         prdata = '0;
    endcase
  end

  // decoder for the byte at the input
  logic [7:0]  b;
  logic        dec_ok;
  logic [20:0] dec_rune_d, rune_out;
  logic [1:0]  dec_pend_d;
  always_comb begin
    b          = text_byte_i;
    dec_ok     = 1'b0;
    dec_rune_d = 21'd0;
    dec_pend_d = 2'd0;
    rune_out   = {13'd0, b};
    if (b < 8'h80) begin
      dec_ok = 1'b1;
    end else if (b < 8'hC0) begin
      dec_rune_d = {rune_q[14:0], b[5:0]};
      rune_out   = dec_rune_d;
      if (pend_q != 2'd0) begin
        dec_pend_d = pend_q - 2'd1;
        dec_ok     = (dec_pend_d == 2'd0) && (dec_rune_d <= MAX_RUNE);
      end else begin
        dec_rune_d = rune_q;
      end
    end else if (b < 8'hE0) begin
      dec_rune_d = {16'd0, b[4:0]};
      dec_pend_d = 2'd1;
    end else if (b < 8'hF0) begin
      dec_rune_d = {17'd0, b[3:0]};
      dec_pend_d = 2'd2;
    end else if (b < 8'hF5) begin
      dec_rune_d = {18'd0, b[2:0]};
      dec_pend_d = 2'd3;
    end
  end

  logic signed [49:0] left_x, top_y, right_x, bot_y, cur_x;
  logic signed [31:0] left_s, top_s;
  always_comb begin
    left_x  = 50'(origin_x_q) + 50'(cursor_q) + 50'(m_off_x_q);
    top_y   = 50'(origin_y_q) + 50'(m_off_y_q);
    left_s  = sat32(left_x);
    top_s   = sat32(top_y);
    right_x = 50'(left_s) + 50'(m_w_q);
    bot_y   = 50'(top_s) + 50'(m_h_q);
    cur_x   = 50'(cursor_q) + 50'(m_adv_q);
  end

  logic signed [16:0] sc;
  assign sc = {1'b0, scale_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      glyph_count_q <= 9'd0;
      scale_q       <= 16'd256;
      origin_x_q    <= '0;
      origin_y_q    <= '0;
      rune_q        <= '0;
      pend_q        <= '0;
      cursor_q      <= '0;
      last_q        <= 1'b0;
      out_valid_o   <= 1'b0;
      lo_q          <= '0;
      hi_q          <= '0;
      mid_q         <= '0;
    end else begin
      if (psel && penable && pwrite) begin
        unique case (paddr[3:2])
          REG_GLYPH_COUNT: glyph_count_q <= pwdata[8:0];
          REG_SCALE:       scale_q       <= pwdata[15:0];
          REG_ORIGIN_X:    origin_x_q    <= pwdata;
          REG_ORIGIN_Y:    origin_y_q    <= pwdata;
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && req_type_i == REQ_TEXT) begin
            last_q <= last_byte_i;
            rune_q <= dec_ok ? rune_out : dec_rune_d;
            pend_q <= dec_pend_d;
            lo_q <= '0;
            hi_q <= lim;
            if (dec_ok && rune_out != 21'd0) state_q <= S_SEARCH;
            else if (last_byte_i) state_q <= S_END;
          end
        end
        S_SEARCH: begin
          if (hi_q > lo_q) begin
            mid_q   <= AW'(mid_sum);
            state_q <= S_READ;
          end else begin
            state_q <= last_q ? S_END : S_IDLE;
          end
        end
        S_READ: state_q <= S_CMP;
        S_CMP: begin
          if (rune_q < r_code) begin
            hi_q    <= CW'(mid_q);
            state_q <= S_SEARCH;
          end else if (rune_q > r_code) begin
            lo_q    <= CW'(mid_q) + CW'(1);
            state_q <= S_SEARCH;
          end else begin
            m_off_x_q <= r_ox * sc;
            m_off_y_q <= r_oy * sc;
            state_q   <= S_MUL;
          end
        end
        S_MUL: begin
          m_w_q   <= r_sw * sc;
          m_h_q   <= r_sh * sc;
          m_adv_q <= r_ax * sc;
          state_q <= S_SUM;
        end
        S_SUM: begin
          kind_o        <= (r_code == SPACE_CODE) ? KIND_SPACE : KIND_GLYPH;
          dest_left_o   <= left_s;
          dest_top_o    <= top_s;
          dest_right_o  <= sat32(right_x);
          dest_bottom_o <= sat32(bot_y);
          tex_x_o       <= r_sx;
          tex_y_o       <= r_sy;
          tex_w_o       <= r_sw;
          tex_h_o       <= r_sh;
          total_width_o <= sat32(cur_x);
          cursor_q      <= sat32(cur_x);
          is_last_o     <= !last_q;
          out_valid_o   <= 1'b1;
          state_q       <= S_GLYPH;
        end
        S_GLYPH: begin
          if (out_ready_i) begin
            out_valid_o <= 1'b0;
            state_q     <= last_q ? S_END : S_IDLE;
          end
        end
        S_END: begin
          if (!out_valid_o) begin
            kind_o        <= KIND_END;
            dest_left_o   <= '0;
            dest_top_o    <= '0;
            dest_right_o  <= '0;
            dest_bottom_o <= '0;
            tex_x_o       <= '0;
            tex_y_o       <= '0;
            tex_w_o       <= '0;
            tex_h_o       <= '0;
            total_width_o <= cursor_q;
            is_last_o     <= 1'b1;
            out_valid_o   <= 1'b1;
          end else if (out_ready_i) begin
            out_valid_o <= 1'b0;
            cursor_q    <= '0;
            rune_q      <= '0;
            pend_q      <= '0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/gtl_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtl_ram: generic single-port-write, single-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gtl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end

endmodule
